// ===== design/tic_pkg.sv =====
`timescale 1ns / 1ps

package tic_pkg;

  localparam int BOUND_W  = 10;
  localparam int COUNT_W  = 17;
  localparam int RESULT_W = 49;
  localparam int SUM_W    = 64;

  // One classified request, as handed from the front end to the back end.
  typedef struct packed {
    logic                      bad;
    logic signed [BOUND_W-1:0] lower;
    logic signed [BOUND_W-1:0] upper;
    logic [COUNT_W-1:0]        count;
  } tic_job_t;

endpackage

// ===== design/trapezoid_integral_of_cube.sv =====
// The front end finds the step by bit-serial division; the back end then runs a
//   bit-serial multiplier and a one-sample-per-cycle difference sweep, and takes a new
//   item only once the last result is loaded; the front end divides the next item
//   meanwhile. A zero count skips the division, the multiplies and the sweep.
// Reset: asynchronous, active low; clears the state machines, queue and output valid.
`timescale 1ns / 1ps

module trapezoid_integral_of_cube import tic_pkg::*; #(
  parameter int unsigned MAX_INTERVALS  = 65536,
  parameter int unsigned OUT_FRAC_BITS  = 16,
  parameter int unsigned STEP_FRAC_BITS = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [BOUND_W-1:0]  lower_bound_i,
  input  logic signed [BOUND_W-1:0]  upper_bound_i,
  input  logic [COUNT_W-1:0]         interval_count_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [RESULT_W-1:0] integral_value_o,
  output logic                       bad_count_o
);

  localparam int HW = STEP_FRAC_BITS + 11;
  localparam int QW = $bits(tic_job_t) + HW;

  logic                 f_valid, f_stall;
  tic_job_t             f_job;
  logic signed [HW-1:0] f_step;
  logic                 b_valid, b_stall;
  tic_job_t             b_job;
  logic signed [HW-1:0] b_step;
  logic [QW-1:0]        q_din, q_dout;

  tic_front #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .STEP_FRAC_BITS(STEP_FRAC_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .lower_bound_i,
    .upper_bound_i,
    .interval_count_i,
    .job_valid_o(f_valid),
    .job_stall_i(f_stall),
    .job_o      (f_job),
    .step_o     (f_step)
  );

  assign q_din = {f_job, f_step};

  tic_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i(f_valid),
    .push_stall_o(f_stall),
    .push_data_i (q_din),
    .pop_valid_o (b_valid),
    .pop_stall_i (b_stall),
    .pop_data_o  (q_dout)
  );

  assign {b_job, b_step} = q_dout;

  tic_back #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS),
    .STEP_FRAC_BITS(STEP_FRAC_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .job_valid_i(b_valid),
    .job_stall_o(b_stall),
    .job_i      (b_job),
    .step_i     (b_step),
    .out_valid_o,
    .out_stall_i,
    .integral_value_o,
    .bad_count_o
  );

endmodule

// ===== design/tic_front.sv =====
`timescale 1ns / 1ps

module tic_front import tic_pkg::*; #(
  parameter int unsigned MAX_INTERVALS  = 65536,
  parameter int unsigned STEP_FRAC_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [BOUND_W-1:0]        lower_bound_i,
  input  logic signed [BOUND_W-1:0]        upper_bound_i,
  input  logic [COUNT_W-1:0]               interval_count_i,
  output logic                             job_valid_o,
  input  logic                             job_stall_i,
  output tic_job_t                         job_o,
  output logic signed [STEP_FRAC_BITS+10:0] step_o
);

  localparam int HW    = STEP_FRAC_BITS + 11;
  localparam int DW    = STEP_FRAC_BITS + BOUND_W;
  localparam int CNT_W = $clog2(DW);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_e;

  front_state_e         state_q, state_d;
  tic_job_t             job_q, job_d;
  logic [DW-1:0]        quo_q, quo_d;
  logic [COUNT_W-1:0]   rem_q, rem_d;
  logic                 neg_q, neg_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  logic signed [BOUND_W:0] diff;
  logic [BOUND_W:0]        mag;
  logic [COUNT_W-1:0]      count_eff;
  logic [COUNT_W:0]        rem_sh;
  logic [COUNT_W:0]        rem_sub;
  logic                    ge;
  logic [HW-1:0]           quo_ext;

  always_comb begin
    diff = {upper_bound_i[BOUND_W-1], upper_bound_i}
         - {lower_bound_i[BOUND_W-1], lower_bound_i};
    mag  = diff[BOUND_W] ? -diff : diff;
    if (32'(interval_count_i) > MAX_INTERVALS) begin
      count_eff = COUNT_W'(MAX_INTERVALS);
    end else begin
      count_eff = interval_count_i;
    end
    rem_sh  = {rem_q, quo_q[DW-1]};
    rem_sub = rem_sh - {1'b0, job_q.count};
    ge      = rem_sh >= {1'b0, job_q.count};
    quo_ext = {1'b0, quo_q};
  end

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          job_d.bad   = interval_count_i == '0;
          job_d.lower = lower_bound_i;
          job_d.upper = upper_bound_i;
          job_d.count = count_eff;
          quo_d       = {mag[BOUND_W-1:0], {STEP_FRAC_BITS{1'b0}}};
          rem_d       = '0;
          neg_d       = diff[BOUND_W];
          cnt_d       = '0;
          state_d     = (interval_count_i == '0) ? F_PUSH : F_DIV;
        end
      end
      F_DIV: begin
        rem_d = ge ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
        quo_d = {quo_q[DW-2:0], ge};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DW - 1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!job_stall_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    cnt_q <= cnt_d;
  end

  assign in_stall_o  = state_q != F_IDLE;
  assign job_valid_o = state_q == F_PUSH;
  assign job_o       = job_q;
  assign step_o      = neg_q ? -quo_ext : quo_ext;

`ifndef NO_ASSERTIONS
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == F_DIV |-> job_q.count != '0)
    else $error("divide started with zero interval count");
`endif

endmodule

// ===== design/tic_queue.sv =====
`timescale 1ns / 1ps

module tic_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_stall_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_stall_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam logic [1:0] FULL = 2'd2;

  logic [1:0]       count_q, count_d;
  logic [WIDTH-1:0] head_q, head_d, tail_q, tail_d;
  logic             push, pop;

  assign push = push_valid_i && (count_q != FULL);
  assign pop  = (count_q != 2'd0) && !pop_stall_i;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q + {1'b0, push} - {1'b0, pop};
    unique case ({push, pop})
      2'b10: begin
        if (count_q == 2'd0) begin
          head_d = push_data_i;
        end else begin
          tail_d = push_data_i;
        end
      end
      2'b01: head_d = tail_q;
      2'b11: head_d = push_data_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign push_stall_o = count_q == FULL;
  assign pop_valid_o  = count_q != 2'd0;
  assign pop_data_o   = head_q;

endmodule

// ===== design/tic_back.sv =====
`timescale 1ns / 1ps

module tic_back import tic_pkg::*; #(
  parameter int unsigned OUT_FRAC_BITS  = 16,
  parameter int unsigned STEP_FRAC_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              job_valid_i,
  output logic                              job_stall_o,
  input  tic_job_t                          job_i,
  input  logic signed [STEP_FRAC_BITS+10:0] step_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [RESULT_W-1:0]        integral_value_o,
  output logic                              bad_count_o
);

  localparam int HW    = STEP_FRAC_BITS + 11;
  localparam int XW_C  = 3 * STEP_FRAC_BITS + 30;
  localparam int XW_P  = STEP_FRAC_BITS + 76;
  localparam int XW    = (XW_C > XW_P) ? XW_C : XW_P;
  localparam int CS    = 3 * STEP_FRAC_BITS - OUT_FRAC_BITS;
  localparam int MC_W  = $clog2(HW);
  localparam int LSQ_W = 2 * BOUND_W;
  localparam int LCB_W = 3 * BOUND_W;
  localparam logic [RESULT_W-1:0] RES_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
  localparam logic [RESULT_W-1:0] RES_MIN = {1'b1, {(RESULT_W-1){1'b0}}};

  typedef enum logic [10:0] {
    B_IDLE  = 11'b000_0000_0001,
    B_SQ    = 11'b000_0000_0010,
    B_CUBE  = 11'b000_0000_0100,
    B_MLOAD = 11'b000_0000_1000,
    B_MRUN  = 11'b000_0001_0000,
    B_COMB1 = 11'b000_0010_0000,
    B_COMB2 = 11'b000_0100_0000,
    B_COMB3 = 11'b000_1000_0000,
    B_SWEEP = 11'b001_0000_0000,
    B_DRAIN = 11'b010_0000_0000,
    B_DONE  = 11'b100_0000_0000
  } back_state_e;

  // Products of the setup phase, then the final sum times step.
  typedef enum logic [2:0] {
    MUL_H2  = 3'd0,
    MUL_H3  = 3'd1,
    MUL_LH  = 3'd2,
    MUL_LH2 = 3'd3,
    MUL_L2H = 3'd4,
    MUL_FIN = 3'd5
  } mul_op_e;

  back_state_e               state_q, state_d;
  mul_op_e                   op_q, op_d;
  logic signed [BOUND_W-1:0] lo_q, lo_d, up_q, up_d;
  logic [COUNT_W-1:0]        n_q, n_d, i_q, i_d;
  logic signed [HW-1:0]      h_q, h_d;
  logic                      bad_q, bad_d;
  logic signed [LSQ_W-1:0]   lsq_q, lsq_d, usq_q, usq_d;
  logic signed [LCB_W-1:0]   lcb_q, lcb_d, ucb_q, ucb_d;
  logic signed [XW-1:0]      ma_q, ma_d, macc_q, macc_d;
  logic [HW-1:0]             mb_q, mb_d;
  logic [MC_W-1:0]           mcnt_q, mcnt_d;
  logic signed [XW-1:0]      tmp_q, tmp_d, x_q, x_d;
  logic signed [XW-1:0]      d1_q, d1_d, d2_q, d2_d, d3_q, d3_d;
  logic signed [SUM_W-1:0]   acc_q, acc_d;
  logic                      hit_q, hit_d;
  logic                      out_valid_q, out_valid_d;
  logic [RESULT_W-1:0]       val_q, val_d;
  logic                      bad_out_q, bad_out_d;

  logic signed [XW-1:0]      madd, mnext, sel_a;
  logic                      mlast;
  logic signed [XW-1:0]      cube_w, fin_w;
  logic [SUM_W-1:0]          cube2;
  logic [XW-RESULT_W:0]      fin_hi;
  logic                      fin_ovf;
  logic [RESULT_W-1:0]       fin_val;

  always_comb begin
    madd  = mb_q[0] ? ma_q : '0;
    mlast = mcnt_q == MC_W'(HW - 1);
    // last bit of the step carries negative weight
    mnext = mlast ? (macc_q - madd) : (macc_q + madd);

    unique case (op_q)
      MUL_H2:  sel_a = {{(XW-HW){h_q[HW-1]}}, h_q};
      MUL_H3:  sel_a = tmp_q;
      MUL_LH:  sel_a = {{(XW-BOUND_W){lo_q[BOUND_W-1]}}, lo_q};
      MUL_LH2: sel_a = tmp_q;
      MUL_L2H: sel_a = {{(XW-LSQ_W){lsq_q[LSQ_W-1]}}, lsq_q};
      MUL_FIN: sel_a = {{(XW-SUM_W){acc_q[SUM_W-1]}}, acc_q};
      default: sel_a = '0;
    endcase

    cube_w = x_q >>> CS;
    cube2  = {cube_w[SUM_W-2:0], 1'b0};

    fin_w   = tmp_q >>> (STEP_FRAC_BITS + 1);
    fin_hi  = fin_w[XW-1:RESULT_W-1];
    fin_ovf = (|fin_hi) && !(&fin_hi);
    if (fin_ovf) begin
      fin_val = fin_w[XW-1] ? RES_MIN : RES_MAX;
    end else begin
      fin_val = fin_w[RESULT_W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    lo_d        = lo_q;
    up_d        = up_q;
    n_d         = n_q;
    i_d         = i_q;
    h_d         = h_q;
    bad_d       = bad_q;
    lsq_d       = lsq_q;
    usq_d       = usq_q;
    lcb_d       = lcb_q;
    ucb_d       = ucb_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    macc_d      = macc_q;
    mcnt_d      = mcnt_q;
    tmp_d       = tmp_q;
    x_d         = x_q;
    d1_d        = d1_q;
    d2_d        = d2_q;
    d3_d        = d3_q;
    acc_d       = acc_q;
    hit_d       = hit_q;
    val_d       = val_q;
    bad_out_d   = bad_out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      B_IDLE: begin
        if (job_valid_i) begin
          lo_d    = job_i.lower;
          up_d    = job_i.upper;
          n_d     = job_i.count;
          h_d     = step_i;
          bad_d   = job_i.bad;
          op_d    = MUL_H2;
          state_d = job_i.bad ? B_DONE : B_SQ;
        end
      end
      B_SQ: begin
        lsq_d   = lo_q * lo_q;
        usq_d   = up_q * up_q;
        state_d = B_CUBE;
      end
      B_CUBE: begin
        lcb_d   = lsq_q * lo_q;
        ucb_d   = usq_q * up_q;
        state_d = B_MLOAD;
      end
      B_MLOAD: begin
        ma_d    = sel_a;
        mb_d    = h_q;
        macc_d  = '0;
        mcnt_d  = '0;
        state_d = B_MRUN;
      end
      B_MRUN: begin
        macc_d = mnext;
        ma_d   = ma_q << 1;
        mb_d   = mb_q >> 1;
        mcnt_d = mcnt_q + MC_W'(1);
        if (mlast) begin
          state_d = B_MLOAD;
          unique case (op_q)
            MUL_H2: begin
              tmp_d = mnext;
              op_d  = MUL_H3;
            end
            MUL_H3: begin
              d3_d = mnext;
              op_d = MUL_LH;
            end
            MUL_LH: begin
              tmp_d = mnext;
              op_d  = MUL_LH2;
            end
            MUL_LH2: begin
              d2_d = mnext;
              op_d = MUL_L2H;
            end
            MUL_L2H: begin
              d1_d    = mnext;
              op_d    = MUL_FIN;
              state_d = B_COMB1;
            end
            MUL_FIN: begin
              tmp_d   = mnext;
              op_d    = MUL_H2;
              state_d = B_DONE;
            end
            default: state_d = B_IDLE;
          endcase
        end
      end
      // forward differences of (a + i*h)^3 at i = 0
      B_COMB1: begin
        tmp_d   = (d1_q << (2 * STEP_FRAC_BITS)) + (d2_q << STEP_FRAC_BITS);
        state_d = B_COMB2;
      end
      B_COMB2: begin
        d1_d    = tmp_q + (tmp_q << 1) + d3_q;
        d2_d    = (d2_q << STEP_FRAC_BITS) + d3_q;
        d3_d    = (d3_q << 1) + (d3_q << 2);
        state_d = B_COMB3;
      end
      B_COMB3: begin
        d2_d    = (d2_q << 1) + (d2_q << 2);
        x_d     = {{(XW-LCB_W){lcb_q[LCB_W-1]}}, lcb_q} << (3 * STEP_FRAC_BITS);
        acc_d   = ({{(SUM_W-LCB_W){lcb_q[LCB_W-1]}}, lcb_q}
                 + {{(SUM_W-LCB_W){ucb_q[LCB_W-1]}}, ucb_q}) << OUT_FRAC_BITS;
        hit_d   = 1'b0;
        i_d     = COUNT_W'(1);
        state_d = (n_q > COUNT_W'(1)) ? B_SWEEP : B_DRAIN;
      end
      B_SWEEP: begin
        x_d   = x_q + d1_q;
        d1_d  = d1_q + d2_q;
        d2_d  = d2_q + d3_q;
        hit_d = 1'b1;
        if (hit_q) begin
          acc_d = acc_q + cube2;
        end
        if (i_q == n_q - COUNT_W'(1)) begin
          state_d = B_DRAIN;
        end else begin
          i_d = i_q + COUNT_W'(1);
        end
      end
      B_DRAIN: begin
        if (hit_q) begin
          acc_d = acc_q + cube2;
        end
        hit_d   = 1'b0;
        op_d    = MUL_FIN;
        state_d = B_MLOAD;
      end
      B_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          val_d       = bad_q ? '0 : fin_val;
          bad_out_d   = bad_q;
          state_d     = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    lo_q      <= lo_d;
    up_q      <= up_d;
    n_q       <= n_d;
    i_q       <= i_d;
    h_q       <= h_d;
    bad_q     <= bad_d;
    lsq_q     <= lsq_d;
    usq_q     <= usq_d;
    lcb_q     <= lcb_d;
    ucb_q     <= ucb_d;
    ma_q      <= ma_d;
    mb_q      <= mb_d;
    macc_q    <= macc_d;
    mcnt_q    <= mcnt_d;
    tmp_q     <= tmp_d;
    x_q       <= x_d;
    d1_q      <= d1_d;
    d2_q      <= d2_d;
    d3_q      <= d3_d;
    acc_q     <= acc_d;
    hit_q     <= hit_d;
    val_q     <= val_d;
    bad_out_q <= bad_out_d;
  end

  assign job_stall_o      = state_q != B_IDLE;
  assign out_valid_o      = out_valid_q;
  assign integral_value_o = val_q;
  assign bad_count_o      = bad_out_q;

`ifndef NO_ASSERTIONS
  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_count_o |-> integral_value_o == '0)
    else $error("error result with nonzero value");

  a_sweep_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_SWEEP |-> (i_q != '0) && (i_q < n_q))
    else $error("sweep index out of range");

  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_MRUN |-> mcnt_q <= MC_W'(HW - 1))
    else $error("multiplier ran past the step width");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == B_DONE))
    else $error("result loaded outside the done state");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import tic_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 300000;
  localparam int unsigned HOLD_CYCLES    = 2000;
  localparam int unsigned SETTLE_CYCLES  = 300;

  typedef struct {
    logic signed [RESULT_W-1:0] value;
    logic                       bad;
  } integral_t;

  class cube_integral_board;
    localparam int      STEP_FRAC  = 24;
    localparam int      OUT_FRAC   = 16;
    localparam int      CUBE_SHIFT = 3 * STEP_FRAC - OUT_FRAC;
    localparam longint  MAX_N      = 65536;
    localparam longint  ONE_FX     = longint'(1) << STEP_FRAC;
    localparam logic signed [127:0] OUT_MAX = (128'sd1 <<< 48) - 128'sd1;
    localparam logic signed [127:0] OUT_MIN = -(128'sd1 <<< 48);

    integral_t   expected_integrals[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    // x has STEP_FRAC fraction bits; result is floor(x^3) at OUT_FRAC fraction bits
    function logic signed [127:0] cube_q(logic signed [127:0] x);
      return (x * x * x) >>> CUBE_SHIFT;
    endfunction

    function integral_t integrate_cube(logic signed [BOUND_W-1:0] lo,
                                       logic signed [BOUND_W-1:0] hi,
                                       logic [COUNT_W-1:0] cnt);
      integral_t          r;
      longint             n, h, x;
      logic [63:0]        acc;
      logic signed [127:0] s_w, h_w, q;
      r.value = '0;
      r.bad   = 1'b0;
      if (cnt == '0) begin
        r.bad = 1'b1;
        return r;
      end
      n = longint'(cnt);
      if (n > MAX_N) n = MAX_N;
      h   = ((longint'(hi) - longint'(lo)) * ONE_FX) / n;
      x   = longint'(lo) * ONE_FX;
      acc = 64'(cube_q(x)) + 64'(cube_q(longint'(hi) * ONE_FX));
      for (longint i = 1; i < n; i++) begin
        x   = x + h;
        acc = acc + (64'(cube_q(x)) << 1);
      end
      s_w = $signed(acc);
      h_w = h;
      q   = (s_w * h_w) >>> (STEP_FRAC + 1);
      if (q > OUT_MAX) q = OUT_MAX;
      else if (q < OUT_MIN) q = OUT_MIN;
      r.value = q[RESULT_W-1:0];
      return r;
    endfunction

    function void note_input(logic signed [BOUND_W-1:0] lo, logic signed [BOUND_W-1:0] hi,
                             logic [COUNT_W-1:0] cnt);
      expected_integrals.push_back(integrate_cube(lo, hi, cnt));
    endfunction

    task check_result(logic signed [RESULT_W-1:0] value, logic bad);
      integral_t want;
      if (expected_integrals.size() == 0) begin
        report($sformatf("unexpected result value=%0d bad=%0b", value, bad));
        return;
      end
      want = expected_integrals.pop_front();
      if (value !== want.value)
        report($sformatf("integral_value got %0d want %0d", value, want.value));
      if (bad !== want.bad)
        report($sformatf("bad_count got %0b want %0b", bad, want.bad));
    endtask
  endclass

  logic                       clk_i            = 1'b0;
  logic                       rst_ni           = 1'b0;
  logic                       in_valid_i       = 1'b0;
  logic                       in_stall_o;
  logic signed [BOUND_W-1:0]  lower_bound_i    = '0;
  logic signed [BOUND_W-1:0]  upper_bound_i    = '0;
  logic [COUNT_W-1:0]         interval_count_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i      = 1'b0;
  logic signed [RESULT_W-1:0] integral_value_o;
  logic                       bad_count_o;

  cube_integral_board integrals = new();
  int unsigned        tx_idle_pct  = 0;
  int unsigned        rx_idle_pct  = 0;
  int unsigned        stuck_cycles = 0;
  bit                 hold_req     = 1'b0;

  trapezoid_integral_of_cube dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .lower_bound_i    (lower_bound_i),
    .upper_bound_i    (upper_bound_i),
    .interval_count_i (interval_count_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .integral_value_o (integral_value_o),
    .bad_count_o      (bad_count_o)
  );

  always #2 clk_i = ~clk_i;

  // sampled mid-cycle: values are stable up to the next rising edge
  always @(negedge clk_i) begin : monitor
    logic moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        integrals.note_input(lower_bound_i, upper_bound_i, interval_count_i);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        integrals.check_result(integral_value_o, bad_count_o);
        moved = 1'b1;
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stuck_cycles < WATCHDOG_LIMIT) @(negedge clk_i);
    $display("** trapezoid_integral_of_cube: FAILED **");
    $finish;
  end

  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic logic signed [BOUND_W-1:0] pick_bound();
    logic [31:0] v;
    if ($urandom_range(9) < 8) v = $urandom_range(512) - 256;
    else v = $urandom();
    return v[BOUND_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    logic [31:0] r;
    logic [31:0] v;
    r = $urandom_range(99);
    if (r < 8) v = 0;
    else if (r < 11) v = $urandom_range(131071, 65500);
    else if (r < 70) v = $urandom_range(16, 1);
    else v = $urandom_range(600, 17);
    return v[COUNT_W-1:0];
  endfunction

  task automatic offer(input logic signed [BOUND_W-1:0] lo, input logic signed [BOUND_W-1:0] hi,
                       input logic [COUNT_W-1:0] cnt);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    lower_bound_i    <= lo;
    upper_bound_i    <= hi;
    interval_count_i <= cnt;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic offer_random();
    offer(pick_bound(), pick_bound(), pick_count());
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (integrals.expected_integrals.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 11;
    rx_idle_pct = 71;
    offer(10'sd3, -10'sd7, 17'd0);
    offer(-10'sd512, 10'sd511, 17'd0);
    offer(-10'sd512, 10'sd511, 17'd1);
    offer(10'sd511, -10'sd512, 17'd1);
    offer(10'sd0, 10'sd511, 17'd1);
    offer(10'sd511, 10'sd0, 17'd1);
    offer(10'sd0, -10'sd512, 17'd1);
    offer(-10'sd512, 10'sd0, 17'd1);
    offer(10'sd5, 10'sd5, 17'd7);
    offer(10'sd0, 10'sd1, 17'd3);
    offer(10'sd1, 10'sd0, 17'd3);
    offer(-10'sd1, 10'sd1, 17'd2);
    offer(-10'sd256, 10'sd256, 17'd4);
    offer(-10'sd256, 10'sd256, 17'd65536);
    offer(-10'sd3, 10'sd100, 17'd65537);
    offer(10'sd7, -10'sd9, 17'd131071);
    offer(-10'sd200, 10'sd37, 17'd0);
    offer(-10'sd1, 10'sd511, 17'd5);
    repeat (24) offer_random();
    drain();

    tx_idle_pct = 71;
    rx_idle_pct = 11;
    repeat (25) offer_random();
    drain();

    // back-pressure: output held off while input keeps coming
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    repeat (8) offer(pick_bound(), pick_bound(), 17'($urandom_range(8, 1)));
    repeat (25) offer_random();
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (integrals.errors == 0 && integrals.expected_integrals.size() == 0) begin
      $display("** trapezoid_integral_of_cube: PASSED **");
    end else begin
      $display("** trapezoid_integral_of_cube: FAILED **");
    end
    $finish;
  end

endmodule
